// File: src/doc_pkg.sv
// Shared types and constants for the directional occupancy counter.
package doc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int ECHO_WIDTH_DEF  = 16;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int LIMIT_W     = 16;
    localparam int DIGIT_W     = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_LIMIT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FAR_LIMIT  = CFG_INDEX_W'(1);

    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST = LIMIT_W'(1740);
    localparam logic [LIMIT_W-1:0] FAR_LIMIT_RST  = LIMIT_W'(2320);

    localparam logic signed [DIGIT_W-1:0] DIGIT_ZERO     = 5'sd0;
    localparam logic signed [DIGIT_W-1:0] DIGIT_ONE      = 5'sd1;
    localparam logic signed [DIGIT_W-1:0] DIGIT_NINE     = 5'sd9;
    localparam logic signed [DIGIT_W-1:0] DIGIT_NEG_NINE = -5'sd9;

    typedef struct packed {
        logic [LIMIT_W-1:0] near_limit_us;
        logic [LIMIT_W-1:0] far_limit_us;
    } cfg_t;

    typedef struct packed {
        logic signed [DIGIT_W-1:0] display_digit;
        logic                      lamp;
        logic                      ranging;
    } status_t;

endpackage

// File: src/doc_cfg.sv
// Echo window limit registers written through the configuration channel.
module doc_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [doc_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [doc_pkg::CFG_DATA_W-1:0]  wr_data,
    output doc_pkg::cfg_t                  cfg
);
    import doc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_limit_us <= NEAR_LIMIT_RST;
            cfg_reg.far_limit_us  <= FAR_LIMIT_RST;
        end else if (wr_en) begin
            case (wr_index)
                REG_NEAR_LIMIT: cfg_reg.near_limit_us <= LIMIT_W'(wr_data);
                REG_FAR_LIMIT:  cfg_reg.far_limit_us  <= LIMIT_W'(wr_data);
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/doc_core.sv
// Sensor edge tracking, saturating count, running digit and lamp state.
module doc_core #(
    parameter int COUNT_WIDTH = doc_pkg::COUNT_WIDTH_DEF,
    parameter int ECHO_WIDTH  = doc_pkg::ECHO_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          entry_level,
    input  logic                          exit_level,
    input  logic [ECHO_WIDTH-1:0]         echo_time_us,
    input  doc_pkg::cfg_t                 cfg,
    output logic signed [COUNT_WIDTH-1:0] occupancy_next,
    output doc_pkg::status_t              status_next
);
    import doc_pkg::*;

    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    logic                          prev_entry_reg, prev_exit_reg;
    logic                          entry_armed_reg, exit_armed_reg;
    logic                          ranging_reg, lamp_reg;
    logic signed [COUNT_WIDTH-1:0] count_reg;
    logic signed [DIGIT_W-1:0]     digit_reg;

    logic                          entry_armed_next, exit_armed_next;
    logic                          ranging_next, lamp_next;
    logic signed [COUNT_WIDTH-1:0] count_next;
    logic signed [DIGIT_W-1:0]     digit_next;

    logic                  entry_rise, exit_rise, entry_arm, exit_arm;
    logic                  inc, dec, count_neg, count_pos;
    logic [ECHO_WIDTH-1:0] lo_limit, hi_limit;

    always_comb begin
        entry_rise = entry_level && !prev_entry_reg;
        exit_rise  = exit_level && !prev_exit_reg;
        entry_arm  = entry_armed_reg || entry_rise;
        exit_arm   = exit_armed_reg || exit_rise;
        inc        = entry_arm && exit_rise;
        dec        = !inc && exit_arm && entry_rise;

        entry_armed_next = (inc || dec) ? 1'b0 : entry_arm;
        exit_armed_next  = (inc || dec) ? 1'b0 : exit_arm;

        if (exit_rise) begin
            ranging_next = 1'b0;
        end else if (entry_rise) begin
            ranging_next = 1'b1;
        end else begin
            ranging_next = ranging_reg;
        end

        count_neg  = count_reg[COUNT_WIDTH-1];
        count_pos  = !count_neg && (count_reg != '0);
        count_next = count_reg;
        digit_next = digit_reg;
        // digit follows the count one step at a time, C remainder sign rules
        if (inc && count_reg != COUNT_MAX) begin
            count_next = count_reg + 1'b1;
            if (!count_neg) begin
                digit_next = (digit_reg == DIGIT_NINE) ? DIGIT_ZERO : digit_reg + DIGIT_ONE;
            end else begin
                digit_next = (digit_reg == DIGIT_ZERO) ? DIGIT_NEG_NINE
                                                       : digit_reg + DIGIT_ONE;
            end
        end else if (dec && count_reg != COUNT_MIN) begin
            count_next = count_reg - 1'b1;
            if (count_pos) begin
                digit_next = (digit_reg == DIGIT_ZERO) ? DIGIT_NINE : digit_reg - DIGIT_ONE;
            end else begin
                digit_next = (digit_reg == DIGIT_NEG_NINE) ? DIGIT_ZERO
                                                           : digit_reg - DIGIT_ONE;
            end
        end

        lo_limit  = ECHO_WIDTH'(cfg.near_limit_us);
        hi_limit  = ECHO_WIDTH'(cfg.far_limit_us);
        lamp_next = lamp_reg;
        if (ranging_next && count_next == '0) begin
            lamp_next = (echo_time_us >= lo_limit) && (echo_time_us <= hi_limit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_entry_reg  <= 1'b0;
            prev_exit_reg   <= 1'b0;
            entry_armed_reg <= 1'b0;
            exit_armed_reg  <= 1'b0;
            ranging_reg     <= 1'b0;
            lamp_reg        <= 1'b0;
            count_reg       <= '0;
            digit_reg       <= DIGIT_ZERO;
        end else if (accept) begin
            prev_entry_reg  <= entry_level;
            prev_exit_reg   <= exit_level;
            entry_armed_reg <= entry_armed_next;
            exit_armed_reg  <= exit_armed_next;
            ranging_reg     <= ranging_next;
            lamp_reg        <= lamp_next;
            count_reg       <= count_next;
            digit_reg       <= digit_next;
        end
    end

    assign occupancy_next            = count_next;
    assign status_next.display_digit = digit_next;
    assign status_next.lamp          = lamp_next;
    assign status_next.ranging       = ranging_next;

endmodule

// File: src/doc_out_reg.sv
// Result register holding one word for the master side.
module doc_out_reg #(
    parameter int COUNT_WIDTH = doc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic signed [COUNT_WIDTH-1:0] occupancy_in,
    input  doc_pkg::status_t              status_in,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [COUNT_WIDTH-1:0] occupancy,
    output doc_pkg::status_t              status
);
    import doc_pkg::*;

    logic                          valid_reg, valid_next;
    logic signed [COUNT_WIDTH-1:0] occupancy_reg;
    status_t                       status_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            occupancy_reg <= occupancy_in;
            status_reg    <= status_in;
        end
    end

    assign out_valid = valid_reg;
    assign occupancy = occupancy_reg;
    assign status    = status_reg;

endmodule

// File: src/directional_occupancy_counter.sv
// Top level of the directional occupancy counter.
// Takes one sensor poll word per cycle and returns one result word per poll, registered
// in the cycle after acceptance; the edge, count and lamp update is combinational and
// loads the state registers, and a result register on the master side lets a new poll
// be taken in the same cycle the previous result is taken, or whenever no result is
// waiting. The window limits are written through the cfg channel, which is always ready.
module directional_occupancy_counter #(
    parameter int COUNT_WIDTH = doc_pkg::COUNT_WIDTH_DEF,
    parameter int ECHO_WIDTH  = doc_pkg::ECHO_WIDTH_DEF,
    parameter int S_TDATA_W   = ((2 + ECHO_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W   = ((COUNT_WIDTH + doc_pkg::DIGIT_W + 2 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_level, exit_level, echo_time_us
    input  logic [S_TDATA_W-1:0]            s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // occupancy, display_digit, lamp, ranging
    output logic [M_TDATA_W-1:0]            m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [doc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [doc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import doc_pkg::*;

    cfg_t                          cfg;
    status_t                       status_next, status_out;
    logic signed [COUNT_WIDTH-1:0] occupancy_next, occupancy_out;
    logic                          s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    doc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    doc_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .ECHO_WIDTH  (ECHO_WIDTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (s_accept),
        .entry_level    (s_tdata[0]),
        .exit_level     (s_tdata[1]),
        .echo_time_us   (s_tdata[2 +: ECHO_WIDTH]),
        .cfg            (cfg),
        .occupancy_next (occupancy_next),
        .status_next    (status_next)
    );

    doc_out_reg #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (s_accept),
        .occupancy_in (occupancy_next),
        .status_in    (status_next),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .occupancy    (occupancy_out),
        .status       (status_out)
    );

    assign m_tdata = M_TDATA_W'({status_out.ranging, status_out.lamp,
                                 status_out.display_digit, occupancy_out});

endmodule

// File: src/doc_checker.sv
// Port-level assertions for the directional occupancy counter, bound to the top level.
module doc_checker #(
    parameter int COUNT_WIDTH = doc_pkg::COUNT_WIDTH_DEF,
    parameter int M_TDATA_W   = ((COUNT_WIDTH + doc_pkg::DIGIT_W + 2 + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);
    import doc_pkg::*;

    logic signed [COUNT_WIDTH-1:0] occ;
    logic signed [DIGIT_W-1:0]     digit;

    assign occ   = m_tdata[COUNT_WIDTH-1:0];
    assign digit = m_tdata[COUNT_WIDTH +: DIGIT_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (digit >= DIGIT_NEG_NINE) && (digit <= DIGIT_NINE))
        else $error("display digit out of range");

    a_digit_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (digit != DIGIT_ZERO) |->
            (occ != '0) && (digit[DIGIT_W-1] == occ[COUNT_WIDTH-1]))
        else $error("display digit sign does not match occupancy");

endmodule

bind directional_occupancy_counter doc_checker #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .M_TDATA_W   (M_TDATA_W)
) u_doc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/directional_occupancy_counter_test.sv
// Testbench for directional_occupancy_counter: directed table and random sensor walks.
module directional_occupancy_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import doc_pkg::*;

    localparam int OCC_W       = COUNT_WIDTH_DEF;
    localparam int ECHO_W      = ECHO_WIDTH_DEF;
    localparam int S_W         = ((2 + ECHO_W + 7) / 8) * 8;
    localparam int M_W         = ((OCC_W + DIGIT_W + 2 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 60_000;
    localparam int PHASE_POLLS = 125;
    localparam int HOLD_OFF    = 64;
    localparam int SHOWN_MAX   = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SPARE = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_SPARE  = {CFG_INDEX_W{1'b1}};

    localparam logic signed [OCC_W-1:0] OCC_MAX = {1'b0, {(OCC_W-1){1'b1}}};
    localparam logic signed [OCC_W-1:0] OCC_MIN = {1'b1, {(OCC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [OCC_W-1:0]   occupancy;
        logic signed [DIGIT_W-1:0] digit;
        logic                      lamp;
        logic                      ranging;
    } tally_t;

    typedef struct packed {
        logic              entry_lvl;
        logic              exit_lvl;
        logic [ECHO_W-1:0] echo;
        logic              typed;
        tally_t            want;
    } poll_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_W-1:0]         m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor state
    logic [LIMIT_W-1:0]      near_us     = NEAR_LIMIT_RST;
    logic [LIMIT_W-1:0]      far_us      = FAR_LIMIT_RST;
    logic                    was_entry   = 1'b0;
    logic                    was_exit    = 1'b0;
    logic                    entry_armed = 1'b0;
    logic                    exit_armed  = 1'b0;
    logic                    ranging_on  = 1'b0;
    logic signed [OCC_W-1:0] head_count  = '0;
    logic                    lamp_on     = 1'b0;

    tally_t    owed_tallies [$];
    poll_row_t directed_rows [$];

    int   tx_idle_pct = 10;
    int   rx_idle_pct = 85;
    int   polls_sent  = 0;
    int   mismatches  = 0;
    int   cycle_count = 0;
    logic rx_blocked  = 1'b0;

    directional_occupancy_counter dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic tally_t advance_tally(logic en, logic ex, logic [ECHO_W-1:0] echo);
        logic   en_rise;
        logic   ex_rise;
        int     occ;
        tally_t t;
        en_rise = en && !was_entry;
        ex_rise = ex && !was_exit;
        if (en_rise) begin
            entry_armed = 1'b1;
            ranging_on  = 1'b1;
        end
        if (ex_rise) begin
            exit_armed = 1'b1;
            ranging_on = 1'b0;
        end
        // increment wins on simultaneous edges since it clears both flags first
        if (entry_armed && ex_rise) begin
            if (head_count != OCC_MAX)
                head_count = head_count + OCC_W'(1);
            entry_armed = 1'b0;
            exit_armed  = 1'b0;
        end
        if (exit_armed && en_rise) begin
            if (head_count != OCC_MIN)
                head_count = head_count - OCC_W'(1);
            entry_armed = 1'b0;
            exit_armed  = 1'b0;
        end
        was_entry = en;
        was_exit  = ex;
        if (ranging_on && head_count == '0)
            lamp_on = (echo >= near_us) && (echo <= far_us);
        occ         = head_count;
        t.occupancy = head_count;
        t.digit     = DIGIT_W'(occ % 10);
        t.lamp      = lamp_on;
        t.ranging   = ranging_on;
        return t;
    endfunction

    function automatic poll_row_t fixed_row(logic en, logic ex, logic [ECHO_W-1:0] echo,
                                            logic signed [OCC_W-1:0] occ,
                                            logic signed [DIGIT_W-1:0] dig,
                                            logic lamp, logic rng);
        poll_row_t r;
        r.entry_lvl      = en;
        r.exit_lvl       = ex;
        r.echo           = echo;
        r.typed          = 1'b1;
        r.want.occupancy = occ;
        r.want.digit     = dig;
        r.want.lamp      = lamp;
        r.want.ranging   = rng;
        return r;
    endfunction

    function automatic poll_row_t open_row(logic en, logic ex, logic [ECHO_W-1:0] echo);
        poll_row_t r;
        r           = '0;
        r.entry_lvl = en;
        r.exit_lvl  = ex;
        r.echo      = echo;
        return r;
    endfunction

    // echo times cluster on the window edges
    function automatic logic [ECHO_W-1:0] pick_echo();
        case ($urandom_range(7))
            0:       return near_us - 1'b1;
            1:       return near_us;
            2:       return near_us + 1'b1;
            3:       return far_us - 1'b1;
            4:       return far_us;
            5:       return far_us + 1'b1;
            6:       return ECHO_W'($urandom);
            default: return $urandom_range(1) ? {ECHO_W{1'b1}} : '0;
        endcase
    endfunction

    task automatic offer_poll(input logic en, input logic ex, input logic [ECHO_W-1:0] echo,
                              input logic typed = 1'b0, input tally_t want = '0);
        tally_t t;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({echo, ex, en});
        do @(posedge aclk); while (!s_tready);
        t = advance_tally(en, ex, echo);
        owed_tallies.push_back(typed ? want : t);
        polls_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_NEAR_LIMIT)
            near_us = value;
        else if (idx == REG_FAR_LIMIT)
            far_us = value;
        @(posedge aclk);
    endtask

    task automatic set_window(input logic [LIMIT_W-1:0] near_v, input logic [LIMIT_W-1:0] far_v);
        write_reg(REG_NEAR_LIMIT, near_v);
        write_reg(REG_FAR_LIMIT, far_v);
        write_reg(CFG_INDEX_W'($urandom_range(REG_LAST_SPARE, REG_FIRST_SPARE)),
                  CFG_DATA_W'($urandom));
    endtask

    task automatic drain_tallies();
        s_tvalid <= 1'b0;
        while (owed_tallies.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random_polls(input int count);
        int   base;
        int   pick;
        int   hold_a;
        int   hold_b;
        logic entry_first;
        base = polls_sent;
        while (polls_sent - base < count) begin
            pick        = $urandom_range(99);
            hold_a      = $urandom_range(2, 1);
            hold_b      = $urandom_range(2, 1);
            entry_first = 1'($urandom_range(1));
            if (pick < 50) begin
                // full passage in either direction
                offer_poll(1'b0, 1'b0, pick_echo());
                repeat (hold_a) offer_poll(entry_first, !entry_first, pick_echo());
                repeat (hold_b) offer_poll(1'b1, 1'b1, pick_echo());
                if ($urandom_range(1))
                    offer_poll(!entry_first, entry_first, pick_echo());
            end else if (pick < 65) begin
                offer_poll(1'b0, 1'b0, pick_echo());
                repeat (hold_a) offer_poll(1'b1, 1'b1, pick_echo());
            end else if (pick < 80) begin
                // walker turns back, leaves a flag armed
                repeat (hold_a) offer_poll(entry_first, !entry_first, pick_echo());
                offer_poll(1'b0, 1'b0, pick_echo());
            end else begin
                repeat (hold_a + hold_b)
                    offer_poll(1'($urandom_range(1)), 1'($urandom_range(1)), pick_echo());
            end
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        tally_t got;
        tally_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !rx_blocked && ($urandom_range(99) >= rx_idle_pct);
            if (m_tvalid && m_tready) begin
                got.occupancy = m_tdata[OCC_W-1:0];
                got.digit     = m_tdata[OCC_W +: DIGIT_W];
                got.lamp      = m_tdata[OCC_W + DIGIT_W];
                got.ranging   = m_tdata[OCC_W + DIGIT_W + 1];
                if (owed_tallies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MAX)
                        $display("unexpected word %h", m_tdata);
                end else begin
                    want = owed_tallies.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= SHOWN_MAX)
                            $display({"mismatch: exp occ %0d digit %0d lamp %0b ranging %0b, ",
                                      "got occ %0d digit %0d lamp %0b ranging %0b"},
                                     want.occupancy, want.digit, want.lamp, want.ranging,
                                     got.occupancy, got.digit, got.lamp, got.ranging);
                    end
                end
            end
        end
    end

    // long receiver stall so the result register fills and input backs up
    initial begin : rx_hold_off
        wait (polls_sent >= 60);
        rx_blocked <= 1'b1;
        repeat (HOLD_OFF) @(posedge aclk);
        rx_blocked <= 1'b0;
    end

    initial begin : stimulus
        logic [LIMIT_W-1:0] near_pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_rows = '{
            fixed_row(1'b0, 1'b0, 16'd0,     16'sd0,  DIGIT_ZERO, 1'b0, 1'b0),
            fixed_row(1'b1, 1'b0, 16'd1740,  16'sd0,  DIGIT_ZERO, 1'b1, 1'b1),
            fixed_row(1'b1, 1'b0, 16'd2320,  16'sd0,  DIGIT_ZERO, 1'b1, 1'b1),
            fixed_row(1'b1, 1'b0, 16'd2321,  16'sd0,  DIGIT_ZERO, 1'b0, 1'b1),
            fixed_row(1'b1, 1'b0, 16'd1739,  16'sd0,  DIGIT_ZERO, 1'b0, 1'b1),
            fixed_row(1'b1, 1'b0, 16'd2000,  16'sd0,  DIGIT_ZERO, 1'b1, 1'b1),
            fixed_row(1'b1, 1'b1, 16'd1000,  16'sd1,  DIGIT_ONE,  1'b1, 1'b0),
            open_row (1'b0, 1'b0, 16'd0),
            open_row (1'b0, 1'b1, 16'd0),
            fixed_row(1'b1, 1'b1, 16'd0,     16'sd0,  DIGIT_ZERO, 1'b0, 1'b1),
            open_row (1'b0, 1'b0, 16'hFFFF),
            fixed_row(1'b1, 1'b1, 16'd2000,  16'sd1,  DIGIT_ONE,  1'b0, 1'b0),
            open_row (1'b0, 1'b0, 16'hFFFF),
            open_row (1'b0, 1'b1, 16'd0),
            open_row (1'b1, 1'b1, 16'd0),
            open_row (1'b0, 1'b0, 16'd0),
            open_row (1'b0, 1'b1, 16'd0),
            fixed_row(1'b1, 1'b1, 16'd1740, -16'sd1, -DIGIT_ONE, 1'b0, 1'b1),
            open_row (1'b0, 1'b0, 16'd0),
            open_row (1'b1, 1'b0, 16'd0),
            open_row (1'b0, 1'b0, 16'd0),
            fixed_row(1'b0, 1'b1, 16'd2320,  16'sd0,  DIGIT_ZERO, 1'b0, 1'b0),
            open_row (1'b1, 1'b0, 16'hAAAA),
            open_row (1'b0, 1'b0, 16'h5555)
        };
        foreach (directed_rows[i])
            offer_poll(directed_rows[i].entry_lvl, directed_rows[i].exit_lvl,
                       directed_rows[i].echo, directed_rows[i].typed, directed_rows[i].want);
        drain_tallies();

        set_window('0, {LIMIT_W{1'b1}});
        run_random_polls(PHASE_POLLS);
        drain_tallies();
        set_window({LIMIT_W{1'b1}}, '0);
        run_random_polls(PHASE_POLLS);
        drain_tallies();

        tx_idle_pct = 85;
        rx_idle_pct = 10;
        near_pick   = LIMIT_W'($urandom);
        set_window(near_pick, near_pick);
        run_random_polls(PHASE_POLLS);
        drain_tallies();
        set_window(LIMIT_W'($urandom), LIMIT_W'($urandom));
        run_random_polls(PHASE_POLLS);
        drain_tallies();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_window(NEAR_LIMIT_RST, FAR_LIMIT_RST);
        run_random_polls(PHASE_POLLS);
        drain_tallies();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
